@@ hw/rtl/bsc_pkg.sv @@
package bsc_pkg;

    localparam int unsigned W = 32;

    localparam logic [2:0] REG_AC1_AC2 = 3'd0;
    localparam logic [2:0] REG_AC3_AC4 = 3'd1;
    localparam logic [2:0] REG_AC5_AC6 = 3'd2;
    localparam logic [2:0] REG_B1_B2   = 3'd3;
    localparam logic [2:0] REG_MC_MD   = 3'd4;
    localparam logic [2:0] REG_OSS     = 3'd5;

    localparam logic [1:0] OSS_RESET = 2'd3;

    localparam logic [W-1:0] K_4000  = 32'd4000;
    localparam logic [W-1:0] K_32768 = 32'd32768;
    localparam logic [W-1:0] K_50000 = 32'd50000;
    localparam logic [W-1:0] K_3038  = 32'd3038;
    localparam logic [W-1:0] K_M7357 = 32'hFFFF_E343;
    localparam logic [W-1:0] K_3791  = 32'd3791;

    localparam logic [5:0] T_SUB  = 6'd0;
    localparam logic [5:0] T_MUL  = 6'd1;
    localparam logic [5:0] T_SHR  = 6'd2;
    localparam logic [5:0] T_DEN  = 6'd3;
    localparam logic [5:0] T_DIV  = 6'd4;
    localparam logic [5:0] T_FIN  = 6'd5;
    localparam logic [5:0] P_B6   = 6'd6;
    localparam logic [5:0] P_SQM  = 6'd7;
    localparam logic [5:0] P_SQ   = 6'd8;
    localparam logic [5:0] P_X1M  = 6'd9;
    localparam logic [5:0] P_X1   = 6'd10;
    localparam logic [5:0] P_X2M  = 6'd11;
    localparam logic [5:0] P_X3   = 6'd12;
    localparam logic [5:0] P_B3A  = 6'd13;
    localparam logic [5:0] P_B3   = 6'd14;
    localparam logic [5:0] P_C1M  = 6'd15;
    localparam logic [5:0] P_C1   = 6'd16;
    localparam logic [5:0] P_C2M  = 6'd17;
    localparam logic [5:0] P_C3   = 6'd18;
    localparam logic [5:0] P_C4A  = 6'd19;
    localparam logic [5:0] P_C4M  = 6'd20;
    localparam logic [5:0] P_B4   = 6'd21;
    localparam logic [5:0] P_B7A  = 6'd22;
    localparam logic [5:0] P_B7M  = 6'd23;
    localparam logic [5:0] P_CHK  = 6'd24;
    localparam logic [5:0] P_DIV  = 6'd25;
    localparam logic [5:0] P_Q    = 6'd26;
    localparam logic [5:0] P_A    = 6'd27;
    localparam logic [5:0] P_AM   = 6'd28;
    localparam logic [5:0] P_AM2  = 6'd29;
    localparam logic [5:0] P_E1   = 6'd30;
    localparam logic [5:0] P_E2M  = 6'd31;
    localparam logic [5:0] P_E2   = 6'd32;
    localparam logic [5:0] P_FIN  = 6'd33;

    typedef struct packed {
        logic       load;
        logic       exec;
        logic [5:0] step;
        logic       div_start;
        logic       load_out;
        logic       err;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic div_done;
    } t_sts;

    function automatic logic [W-1:0] asr(input logic [W-1:0] v, input int unsigned s);
        logic signed [W-1:0] sv;
        sv = $signed(v);
        return W'(sv >>> s);
    endfunction

endpackage

@@ hw/rtl/bsc_div.sv @@
module bsc_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [bsc_pkg::W-1:0] i_dividend,
    input  logic [bsc_pkg::W-1:0] i_divisor,
    output logic [bsc_pkg::W-1:0] o_quot,
    output logic                 o_done
);
    import bsc_pkg::*;

    logic [W-1:0] r_q;
    logic [W-1:0] r_d;
    logic [W:0]   r_r;
    logic [5:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [W:0]   n_r;
    logic         n_bit;

    // one quotient bit per cycle, restoring
    always_comb begin
        n_r   = {r_r[W-1:0], r_q[W-1]};
        n_bit = (n_r >= {1'b0, r_d});
        if (n_bit) begin
            n_r = n_r - {1'b0, r_d};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_d <= i_divisor;
            r_r <= '0;
        end else if (r_busy) begin
            r_r <= n_r;
            r_q <= {r_q[W-2:0], n_bit};
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

@@ hw/rtl/bsc_datapath.sv @@
module bsc_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [2:0]            i_cfg_index,
    input  logic [bsc_pkg::W-1:0] i_cfg_data,
    input  logic                  i_cmd_bit,
    input  logic [23:0]           i_raw,
    input  bsc_pkg::t_cmd         i_cmd,
    output bsc_pkg::t_sts         o_sts,
    output logic                  o_is_pressure,
    output logic [bsc_pkg::W-1:0] o_value,
    output logic                  o_div_error
);
    import bsc_pkg::*;

    logic [W-1:0] r_cal0, r_cal1, r_cal2, r_cal3, r_cal4;
    logic [1:0]   r_oss;
    logic [W-1:0] r_tf;
    logic         r_cmd;
    logic [23:0]  r_raw;
    logic [W-1:0] r_t, r_m, r_x1, r_sq, r_b6, r_b3, r_b4, r_up, r_p, r_res;
    logic         r_neg;
    logic         r_opress;
    logic [W-1:0] r_oval;
    logic         r_oerr;

    logic [W-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [W-1:0] mul_a, mul_b, prod;
    logic [W-1:0] den, mc_sh, dvd, dvs, quot, tq, b5, sum;
    logic         div_done;

    assign ac1 = W'($signed(r_cal0[31:16]));
    assign ac2 = W'($signed(r_cal0[15:0]));
    assign ac3 = W'($signed(r_cal1[31:16]));
    assign ac4 = {16'd0, r_cal1[15:0]};
    assign ac5 = {16'd0, r_cal2[31:16]};
    assign ac6 = {16'd0, r_cal2[15:0]};
    assign b1  = W'($signed(r_cal3[31:16]));
    assign b2  = W'($signed(r_cal3[15:0]));
    assign mc  = W'($signed(r_cal4[31:16]));
    assign md  = W'($signed(r_cal4[15:0]));

    assign den   = r_x1 + md;
    assign mc_sh = mc << 11;

    always_comb begin
        mul_a = r_t;
        mul_b = r_t;
        unique case (i_cmd.step)
            T_MUL: begin
                mul_b = ac5;
            end
            P_SQM: begin
                mul_a = r_b6;
                mul_b = r_b6;
            end
            P_X1M: begin
                mul_a = b2;
                mul_b = r_sq;
            end
            P_X2M: begin
                mul_a = ac2;
                mul_b = r_b6;
            end
            P_C1M: begin
                mul_a = ac3;
                mul_b = r_b6;
            end
            P_C2M: begin
                mul_a = b1;
                mul_b = r_sq;
            end
            P_C4M: begin
                mul_b = ac4;
            end
            P_B7M: begin
                mul_b = K_50000 >> r_oss;
            end
            P_AM2: begin
                mul_a = r_m;
                mul_b = K_3038;
            end
            P_E2M: begin
                mul_a = K_M7357;
                mul_b = r_p;
            end
            default: begin
                mul_a = r_t;
                mul_b = r_t;
            end
        endcase
    end

    assign prod = W'(mul_a * mul_b);

    // divider works on magnitudes; sign is fixed up afterwards for temperature
    always_comb begin
        if (r_cmd) begin
            dvd = r_m[W-1] ? r_m : (r_m << 1);
            dvs = r_b4;
        end else begin
            dvd = mc_sh[W-1] ? (~mc_sh + W'(1)) : mc_sh;
            dvs = r_t[W-1] ? (~r_t + W'(1)) : r_t;
        end
    end

    bsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_quot     (quot),
        .o_done     (div_done)
    );

    assign tq  = r_neg ? (~quot + W'(1)) : quot;
    assign b5  = r_x1 + tq;
    assign sum = r_t + {{(W-2){1'b0}}, {2{r_t[W-1]}}};

    always_comb begin
        o_sts.div_done = div_done;
        o_sts.zero     = (i_cmd.step == T_DEN) ? (den == '0) : (r_b4 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal0 <= '0;
            r_cal1 <= '0;
            r_cal2 <= '0;
            r_cal3 <= '0;
            r_cal4 <= '0;
            r_oss  <= OSS_RESET;
            r_tf   <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_AC1_AC2: r_cal0 <= i_cfg_data;
                    REG_AC3_AC4: r_cal1 <= i_cfg_data;
                    REG_AC5_AC6: r_cal2 <= i_cfg_data;
                    REG_B1_B2:   r_cal3 <= i_cfg_data;
                    REG_MC_MD:   r_cal4 <= i_cfg_data;
                    REG_OSS:     r_oss  <= i_cfg_data[1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.exec && i_cmd.step == T_FIN) begin
                r_tf <= b5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_cmd_bit;
            r_raw <= i_raw;
        end
        if (i_cmd.exec) begin
            unique case (i_cmd.step)
                T_SUB: r_t  <= {16'd0, r_raw[15:0]} - ac6;
                T_SHR: r_x1 <= asr(r_m, 15);
                T_DEN: r_t  <= den;
                T_DIV: r_neg <= mc_sh[W-1] ^ r_t[W-1];
                T_FIN: r_res <= asr(b5 + W'(8), 4);
                P_B6: begin
                    r_b6 <= r_tf - K_4000;
                    r_up <= {8'd0, r_raw} >> (4'd8 - {2'd0, r_oss});
                end
                P_SQ:  r_sq <= asr(r_m, 12);
                P_X1:  r_x1 <= asr(r_m, 11);
                P_X3:  r_t  <= r_x1 + asr(r_m, 11);
                P_B3A: r_t  <= (((ac1 << 2) + r_t) << r_oss) + W'(2);
                P_B3:  r_b3 <= asr(sum, 2);
                P_C1:  r_x1 <= asr(r_m, 13);
                P_C3:  r_t  <= asr(r_x1 + asr(r_m, 16) + W'(2), 2);
                P_C4A: r_t  <= r_t + K_32768;
                P_B4:  r_b4 <= r_m >> 15;
                P_B7A: r_t  <= r_up - r_b3;
                P_Q:   r_p  <= r_m[W-1] ? (quot << 1) : quot;
                P_A:   r_t  <= asr(r_p, 8);
                P_E1:  r_x1 <= asr(r_m, 16);
                P_E2:  r_t  <= r_x1 + asr(r_m, 16) + K_3791;
                P_FIN: r_res <= r_p + asr(r_t, 4);
                T_MUL, P_SQM, P_X1M, P_X2M, P_C1M, P_C2M, P_C4M, P_B7M,
                P_AM, P_AM2, P_E2M: r_m <= prod;
                default: begin
                end
            endcase
        end
        if (i_cmd.load_out) begin
            r_opress <= r_cmd;
            r_oval   <= i_cmd.err ? '0 : r_res;
            r_oerr   <= i_cmd.err;
        end
    end

    assign o_is_pressure = r_opress;
    assign o_value       = r_oval;
    assign o_div_error   = r_oerr;

endmodule

@@ hw/rtl/bsc_ctrl.sv @@
module bsc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_cmd,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    input  bsc_pkg::t_sts i_sts,
    output bsc_pkg::t_cmd o_cmd
);
    import bsc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state, n_state;
    logic [5:0] r_step, n_step;
    logic       r_err, n_err;
    logic       r_ovalid, n_ovalid;
    logic       accept, emit;

    assign accept = (r_state == S_IDLE) && i_in_valid;
    assign emit   = (r_state == S_OUT) && (!r_ovalid || i_out_ready);

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_err    = r_err;
        n_ovalid = r_ovalid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RUN;
                    n_step  = i_in_cmd ? P_B6 : T_SUB;
                    n_err   = 1'b0;
                end
            end
            S_RUN: begin
                if (r_step == T_DIV || r_step == P_DIV) begin
                    n_state = S_DIV;
                end else if ((r_step == T_DEN || r_step == P_CHK) && i_sts.zero) begin
                    n_err   = 1'b1;
                    n_state = S_OUT;
                end else if (r_step == T_FIN || r_step == P_FIN) begin
                    n_state = S_OUT;
                end else begin
                    n_step = r_step + 6'd1;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_RUN;
                    n_step  = r_step + 6'd1;
                end
            end
            S_OUT: begin
                if (emit) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= T_SUB;
            r_err    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_err    <= n_err;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        o_cmd.load      = accept;
        o_cmd.exec      = (r_state == S_RUN);
        o_cmd.step      = r_step;
        o_cmd.div_start = (r_state == S_RUN) && (r_step == T_DIV || r_step == P_DIV);
        o_cmd.load_out  = emit;
        o_cmd.err       = r_err;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

endmodule

@@ hw/rtl/barometric_sensor_compensation.sv @@
// Compensates raw sensor words: tuser 0 is a raw temperature word (16 bits used),
// tuser 1 a raw pressure word. One item is worked on at a time, the work mostly in the
// bit-serial divider, the rest single steps through one shared 32x32 multiplier.
// A result waits in an output register while the next item is computed. The
// temperature factor kept from the last good temperature item feeds pressure items.
// Calibration writes go through the cfg channel (index 0..5); the user must write
// them only while the block is idle, which the block itself does not enforce.
module barometric_sensor_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // raw_word
    input  logic        i_s_axis_tuser,  // cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // value[31:0], div_error[32], zeros
    output logic        o_m_axis_tuser   // is_pressure
);
    import bsc_pkg::*;

    t_cmd        cmd;
    t_sts        sts;
    logic [31:0] value;
    logic        div_error;

    bsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_cmd    (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bsc_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd_bit     (i_s_axis_tuser),
        .i_raw         (i_s_axis_tdata),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_is_pressure (o_m_axis_tuser),
        .o_value       (value),
        .o_div_error   (div_error)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = {7'd0, div_error, value};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while busy");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[32] |-> o_m_axis_tdata[31:0] == 32'd0)
        else $error("error item with nonzero value");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready))
        else $error("result without work");
`endif

endmodule
